### src/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package sida_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ProdW    = 2 * ValueW;
  localparam int unsigned QuotW    = ProdW - 35;

  localparam logic [CharW-1:0]  ChMinus = 6'd45;
  localparam logic [CharW-1:0]  ChZero  = 6'd48;
  // floor(x * Recip10 / 2^35) == floor(x / 10) for every 32-bit x
  localparam logic [ValueW-1:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic load;
    logic prep;
    logic divide;
    logic emit_sign;
    logic emit_digit;
  } sida_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic neg;
    logic last_digit;
    logic slot_free;
  } sida_status_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StPrep   = 5'b00010,
    StDiv    = 5'b00100,
    StSign   = 5'b01000,
    StDigits = 5'b10000
  } sida_state_e;

endpackage

### src/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Usage:
//   The slave stream takes one signed 32-bit value per transaction on
//   s_axis_tdata_i. The master stream returns its decimal text, one ASCII
//   character per transaction, most significant first: a leading '-' for
//   negative values, no leading zeros, "0" for zero. m_axis_tlast_o marks
//   the final character, so each value gives 1 to 11 transactions.
//   Sequence: the accepting edge forms the magnitude, the prepare state
//   multiplies by the reciprocal of ten, then one digit is produced per
//   cycle, followed by the sign slot and the character output.
//   One value is handled at a time; s_axis_tready_o is high while idle.
//   A stalled receiver holds the current character in the output register
//   and pauses the block; nothing is dropped. Reset returns to idle with
//   the output stream empty.
module signed_int_to_decimal_ascii_top
  import sida_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] character, [7:6] zero
  output logic        m_axis_tlast_o    // last
);

  sida_cmd_t    cmd;
  sida_status_t status;
  sida_state_e  state;
  logic [CharW-1:0] out_char;

  sida_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  sida_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata_i),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_char};

`ifndef SYNTHESIS
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_char == ChMinus) ||
                        ((out_char >= ChZero) && (out_char <= ChZero + 6'd9)))
    else $error("character code out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_char == ChMinus) |-> !m_axis_tlast_o)
    else $error("minus sign marked as last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sign || cmd.emit_digit) |-> status.slot_free)
    else $error("character emitted over a held one");

  a_idle_only_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state == StIdle))
    else $error("ready outside idle");
`endif

endmodule

### src/sida_datapath.sv
// Datapath: magnitude, reciprocal divide by ten, digit store and output register.
module sida_datapath
  import sida_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ValueW-1:0]   value_i,
  input  sida_cmd_t           cmd_i,
  input  logic                out_ready_i,
  output sida_status_t        status_o,
  output logic                out_valid_o,
  output logic [CharW-1:0]    out_char_o,
  output logic                out_last_o
);

  logic                neg_q, neg_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [CountW-1:0]   nd_q, nd_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    out_char_q, out_char_d;
  logic                out_last_q, out_last_d;
  logic [DigitW-1:0]   dig_q [MaxDigits];

  logic [QuotW-1:0]    quot;
  logic [ValueW:0]     quot_x10;
  logic [ValueW-1:0]   rem_full;
  logic [DigitW-1:0]   rem;
  logic [CountW-1:0]   rd_idx;

  assign quot     = prod_q[ProdW-1:35];
  assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign rem_full = mag_q - quot_x10[ValueW-1:0];
  assign rem      = rem_full[DigitW-1:0];
  assign rd_idx   = nd_q - CountW'(1);

  always_comb begin
    neg_d       = neg_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    nd_d        = nd_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.load) begin
      neg_d = value_i[ValueW-1];
      mag_d = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
      nd_d  = '0;
    end
    if (cmd_i.prep) begin
      prod_d = ProdW'(mag_q) * ProdW'(Recip10);
    end
    if (cmd_i.divide) begin
      mag_d  = ValueW'(quot);
      prod_d = ProdW'(quot) * ProdW'(Recip10);
      nd_d   = nd_q + CountW'(1);
    end
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = ChMinus;
      out_last_d  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = ChZero + CharW'(dig_q[rd_idx]);
      out_last_d  = (nd_q == CountW'(1));
      nd_d        = rd_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nd_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      nd_q        <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    prod_q     <= prod_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (cmd_i.divide) begin
      dig_q[nd_q] <= rem;
    end
  end

  assign status_o.quot_zero  = (quot == '0);
  assign status_o.neg        = neg_q;
  assign status_o.last_digit = (nd_q == CountW'(1));
  assign status_o.slot_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

### src/sida_ctrl.sv
// Controller state machine sequencing load, divide loop and character output.
module sida_ctrl
  import sida_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sida_status_t  status_i,
  output sida_cmd_t     cmd_o,
  output sida_state_e   state_o
);

  sida_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.divide = 1'b1;
        if (status_i.quot_zero) begin
          state_d = StSign;
        end
      end
      StSign: begin
        if (!status_i.neg) begin
          state_d = StDigits;
        end else if (status_i.slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StDigits;
        end
      end
      StDigits: begin
        if (status_i.slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

### verif/tb.sv
// Testbench for the signed 32-bit integer to decimal ASCII converter.
module tb
  import sida_pkg::*;
();

  localparam int          CycleLimit = 500000;
  localparam int unsigned Radix      = 10;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 40;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } ascii_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [5:0] character, [7:6] zero
  logic        m_axis_tlast_o;

  ascii_char_t text_q[$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_on;
  event        hold_go;

  signed_int_to_decimal_ascii_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // decimal text of one value, sign first, most significant digit first
  function automatic void predict_text(input logic [ValueW-1:0] v);
    logic [DigitW-1:0] digs[MaxDigits];
    logic [ValueW-1:0] mag;
    logic              neg;
    int                nd;
    neg = v[ValueW-1];
    mag = neg ? (ValueW'(0) - v) : v;
    nd  = 0;
    do begin
      digs[nd] = DigitW'(mag % Radix);
      nd++;
      mag = mag / Radix;
    end while (mag != 0 && nd < MaxDigits);
    if (neg) begin
      text_q.push_back('{ch: ChMinus, last: 1'b0});
    end
    for (int k = nd - 1; k >= 0; k--) begin
      text_q.push_back('{ch: ChZero + CharW'(digs[k]), last: (k == 0)});
    end
  endfunction

  // mix of full-range words and values of a chosen digit count
  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] v;
    longint            limit;
    int unsigned       ndig;
    if ($urandom_range(3) == 0) begin
      v = $urandom();
    end else begin
      ndig  = $urandom_range(1, MaxDigits);
      limit = 1;
      for (int i = 0; i < ndig; i++) limit = limit * Radix;
      v = ValueW'(longint'($urandom()) % limit);
      if ($urandom_range(1) == 1) v = ValueW'(0) - v;
    end
    return v;
  endfunction

  task automatic send_value(input logic [ValueW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_text(v);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [ValueW-1:0] vals[$];
    send_idle_pct = 0;
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
             32'd1234567890, -32'sd1234567890, 32'd7, -32'sd9, 32'd1000000007};
    foreach (vals[i]) send_value(vals[i]);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
    repeat (n) send_value(rand_value());
    wait_drained();
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    -> hold_go;
    repeat (12) send_value(rand_value());
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_on) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    ascii_char_t exp_ch;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual data %0d last %0b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        exp_ch = text_q.pop_front();
        if (m_axis_tdata_o !== {2'b00, exp_ch.ch}) begin
          $display("%0t: character mismatch, expected %0d, actual %0d",
                   $time, exp_ch.ch, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== exp_ch.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, exp_ch.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d characters still expected", $time, text_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(100, 14, 80);
    test_random(100, 80, 14);
    test_random(100, 0, 0);
    test_backpressure();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
